/* hw/rtl/clebu_pkg.sv */
// ----------------------------------------------------------------------------
// clebu_pkg - shared definitions for the cursor line edit buffer
// Item kinds, character codes, the cell operation code and the control
// group that the sequencer broadcasts along the row of character cells.
// ----------------------------------------------------------------------------
package clebu_pkg;

	// Width of the length, cursor and index counters; covers the largest line.
	localparam int CNT_W          = 6;
	localparam int CHAR_W         = 8;
	localparam int LINE_DEPTH_DEF = 63;

	localparam logic [CHAR_W-1:0] SYM_BACK     = 8'h42;
	localparam logic [CHAR_W-1:0] SYM_LEFT     = 8'h4C;
	localparam logic [CHAR_W-1:0] SYM_RIGHT    = 8'h52;
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;

	typedef enum logic [1:0] {
		KIND_EDIT  = 2'd0,
		KIND_START = 2'd1,
		KIND_EMIT  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_op_t;

	// Broadcast to every cell: each cell compares its own index with pos/lim.
	typedef struct packed {
		cell_op_t                op;
		logic [CNT_W-1:0]        pos;
		logic [CNT_W-1:0]        lim;
		logic [CHAR_W-1:0]       sym;
	} cell_ctrl_t;

endpackage

/* hw/rtl/cursor_line_edit_buffer_unit.sv */
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_unit - line editor with an edit cursor
// Keeps one bounded line in a row of character cells and edits it by start,
// edit and emit items; an emit streams the line and a closing newline.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake                  Payload
// item     in         item_valid / item_stall    kind, symbol
// result   out        result_valid / result_stall out_char, last, overflowed
//
// A start or edit beat is taken at once, and any shift of the row of cells
// happens in the same edge, so the next item may follow at once.
// An emit beat takes line length + 1 result beats (at most LINE_DEPTH + 1),
// one per cycle while the result side does not stall; each streamed character
// rotates the row by one place, so the line is back in order afterwards.
// item_stall is high for the whole of an emit.
// After reset the line is empty, the cursor is at its start and the overflow
// flag is clear; the cells themselves are not cleared, as only characters
// below the line length are ever streamed out.
module cursor_line_edit_buffer_unit #(
	parameter int LINE_DEPTH = clebu_pkg::LINE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [1:0]                       kind,
	input  logic [clebu_pkg::CHAR_W-1:0]     symbol,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [clebu_pkg::CHAR_W-1:0]     out_char,
	output logic                             last,
	output logic                             overflowed
);

	localparam int CNT_W = clebu_pkg::CNT_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LINE_DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t                       state_q;
	logic [CNT_W-1:0]             len_q;
	logic [CNT_W-1:0]             cur_q;
	logic                         drop_q;
	logic [CNT_W-1:0]             idx_q;
	logic                         res_valid_q;
	logic [clebu_pkg::CHAR_W-1:0] res_char_q;
	logic                         res_last_q;
	logic                         res_over_q;

	logic [CNT_W-1:0]             len_d;
	logic [CNT_W-1:0]             cur_d;
	logic                         drop_d;
	logic                         go_emit;
	logic                         accept;
	logic                         out_free;
	clebu_pkg::cell_ctrl_t        ctrl;
	logic [clebu_pkg::CHAR_W-1:0] head_char;

	assign item_stall = (state_q == ST_EMIT);
	assign accept     = item_valid && !item_stall;
	// The result register may be loaded when empty or when its beat leaves.
	assign out_free   = !res_valid_q || !result_stall;

	// Decode the accepted item into one broadcast operation for the cells and
	// the next length, cursor and overflow flag.
	always_comb begin
		ctrl.op  = clebu_pkg::CELL_HOLD;
		ctrl.pos = cur_q;
		ctrl.lim = len_q;
		ctrl.sym = symbol;
		len_d    = len_q;
		cur_d    = cur_q;
		drop_d   = drop_q;
		go_emit  = 1'b0;
		if (state_q == ST_IDLE && accept) begin
			unique case (clebu_pkg::kind_t'(kind))
				clebu_pkg::KIND_START: begin
					// The start symbol is always stored literally as the first
					// character; the line is never full at this point.
					ctrl.op  = clebu_pkg::CELL_INSERT;
					ctrl.pos = '0;
					ctrl.lim = '0;
					len_d    = ONE_C;
					cur_d    = ONE_C;
					drop_d   = 1'b0;
				end
				clebu_pkg::KIND_EDIT: begin
					priority if (symbol == clebu_pkg::SYM_BACK) begin
						// Backspace at the start of the line is ignored.
						if (cur_q != '0) begin
							ctrl.op  = clebu_pkg::CELL_DELETE;
							ctrl.pos = cur_q - ONE_C;
							ctrl.lim = len_q - ONE_C;
							len_d    = len_q - ONE_C;
							cur_d    = cur_q - ONE_C;
						end
					end else if (symbol == clebu_pkg::SYM_LEFT) begin
						if (cur_q != '0) begin
							cur_d = cur_q - ONE_C;
						end
					end else if (symbol == clebu_pkg::SYM_RIGHT) begin
						if (cur_q < len_q) begin
							cur_d = cur_q + ONE_C;
						end
					end else if (len_q == DEPTH_C) begin
						// A full line drops the character and remembers that it did so.
						drop_d = 1'b1;
					end else begin
						ctrl.op = clebu_pkg::CELL_INSERT;
						len_d   = len_q + ONE_C;
						cur_d   = cur_q + ONE_C;
					end
				end
				clebu_pkg::KIND_EMIT: begin
					go_emit = 1'b1;
				end
				clebu_pkg::KIND_NONE: begin
				end
			endcase
		end else if (state_q == ST_EMIT && out_free && idx_q != len_q) begin
			// Streaming a character: rotate the used part of the row by one.
			ctrl.op  = clebu_pkg::CELL_ROTATE;
			ctrl.lim = len_q - ONE_C;
		end
	end

	clebu_row #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_row (
		.clk      (clk),
		.ctrl     (ctrl),
		.head_char(head_char)
	);

	// Sequencer: line bookkeeping, emit counter and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			cur_q       <= '0;
			drop_q      <= 1'b0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
			res_char_q  <= '0;
			res_last_q  <= 1'b0;
			res_over_q  <= 1'b0;
		end else begin
			len_q  <= len_d;
			cur_q  <= cur_d;
			drop_q <= drop_d;
			// During an emit the result register is reloaded below whenever
			// its beat leaves, so it is only emptied here outside an emit.
			if (res_valid_q && !result_stall && state_q != ST_EMIT) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (go_emit) begin
						state_q <= ST_EMIT;
						idx_q   <= '0;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_over_q  <= drop_q;
						if (idx_q == len_q) begin
							res_char_q <= clebu_pkg::NEWLINE_CODE;
							res_last_q <= 1'b1;
							state_q    <= ST_IDLE;
						end else begin
							res_char_q <= head_char;
							res_last_q <= 1'b0;
							idx_q      <= idx_q + ONE_C;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign out_char     = res_char_q;
	assign last         = res_last_q;
	assign overflowed   = res_over_q;

	// The cursor never passes the end of the line.
	a_cursor_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q)
		else $error("cursor beyond end of line");

	// The line never outgrows the row of cells.
	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= DEPTH_C)
		else $error("line length beyond depth");

	// Finishing an emit puts the closing newline into the result register.
	a_emit_ends_newline: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free && idx_q == len_q)
		|=> (res_valid_q && res_last_q && res_char_q == clebu_pkg::NEWLINE_CODE))
		else $error("emit did not close with a newline");

	// The line is not edited while it is being streamed out.
	a_line_frozen_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |=> ($stable(len_q) && $stable(cur_q) && $stable(drop_q)))
		else $error("line changed during emit");

	// The streaming counter never runs past the line length.
	a_idx_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (idx_q <= len_q))
		else $error("emit index beyond line length");

endmodule

/* hw/rtl/clebu_cell.sv */
// ----------------------------------------------------------------------------
// clebu_cell - one character position of the line
// Holds one character and, by the broadcast operation, keeps it, takes the
// new symbol, the character of its left or right neighbour, or the head character.
// ----------------------------------------------------------------------------
module clebu_cell #(
	parameter int IDX = 0
) (
	input  logic                             clk,
	input  clebu_pkg::cell_ctrl_t            ctrl,
	input  logic [clebu_pkg::CHAR_W-1:0]     left_char,
	input  logic [clebu_pkg::CHAR_W-1:0]     right_char,
	input  logic [clebu_pkg::CHAR_W-1:0]     head_char,
	output logic [clebu_pkg::CHAR_W-1:0]     char_out
);

	localparam logic [clebu_pkg::CNT_W-1:0] IDX_C = clebu_pkg::CNT_W'(IDX);

	logic [clebu_pkg::CHAR_W-1:0] char_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			clebu_pkg::CELL_INSERT: begin
				// Open a gap at the cursor: cells above it move up by one.
				if (IDX_C == ctrl.pos) begin
					char_q <= ctrl.sym;
				end else if (IDX_C > ctrl.pos && IDX_C <= ctrl.lim) begin
					char_q <= left_char;
				end
			end
			clebu_pkg::CELL_DELETE: begin
				if (IDX_C >= ctrl.pos && IDX_C < ctrl.lim) begin
					char_q <= right_char;
				end
			end
			clebu_pkg::CELL_ROTATE: begin
				// The first character wraps round to the last used place.
				if (IDX_C < ctrl.lim) begin
					char_q <= right_char;
				end else if (IDX_C == ctrl.lim) begin
					char_q <= head_char;
				end
			end
			clebu_pkg::CELL_HOLD: begin
			end
			default: begin
			end
		endcase
	end

	assign char_out = char_q;

endmodule

/* hw/rtl/clebu_row.sv */
// ----------------------------------------------------------------------------
// clebu_row - the row of character cells
// Chains LINE_DEPTH cells so that each sees both neighbours and the head of
// the line; the head cell drives the character that is streamed out.
// ----------------------------------------------------------------------------
module clebu_row #(
	parameter int LINE_DEPTH = clebu_pkg::LINE_DEPTH_DEF
) (
	input  logic                             clk,
	input  clebu_pkg::cell_ctrl_t            ctrl,
	output logic [clebu_pkg::CHAR_W-1:0]     head_char
);

	logic [clebu_pkg::CHAR_W-1:0] chars [LINE_DEPTH];

	for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_cell
		logic [clebu_pkg::CHAR_W-1:0] left_c;
		logic [clebu_pkg::CHAR_W-1:0] right_c;

		if (g == 0) begin : g_first
			assign left_c = chars[g];
		end else begin : g_inner_l
			assign left_c = chars[g-1];
		end

		if (g == LINE_DEPTH - 1) begin : g_last
			assign right_c = chars[g];
		end else begin : g_inner_r
			assign right_c = chars[g+1];
		end

		clebu_cell #(
			.IDX(g)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.left_char (left_c),
			.right_char(right_c),
			.head_char (chars[0]),
			.char_out  (chars[g])
		);
	end

	assign head_char = chars[0];

endmodule
